// ===== hw/rtl/tbsw_pkg.sv =====
// Package for the transmit buffer stall watchdog.
// Holds the slot count, function codes, word types and the count and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbsw_pkg;

	localparam int SLOTS = 8;
	localparam int HANDLE_W = 32;
	localparam int PEND_W = 4;
	localparam int CNT_W = ($clog2(SLOTS + 1) > PEND_W) ? $clog2(SLOTS + 1) : PEND_W;
	localparam logic [CNT_W-1:0] PEND_MAX = CNT_W'((1 << PEND_W) - 1);

	typedef enum logic [1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_RECYCLE = 2'd1,
		FUNC_TICK    = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [HANDLE_W-1:0] handle;
	} req_word_t;

	typedef struct packed {
		logic [PEND_W-1:0] pending_count;
		logic              stuck;
		logic              restart_request;
	} rsp_word_t;

	// command broadcast to every slot cell
	typedef struct packed {
		logic                en;
		logic                alloc;
		logic                recycle;
		logic [HANDLE_W-1:0] handle;
	} cell_cmd_t;

	// per-cell status back to the top level
	typedef struct packed {
		logic hit;
		logic occ;
		logic occ_next;
	} cell_stat_t;

	function automatic logic [CNT_W-1:0] count_ones(input logic [SLOTS-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < SLOTS; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	function automatic logic [PEND_W-1:0] sat_pending(input logic [CNT_W-1:0] n);
		logic [PEND_W-1:0] r;
		if (n > PEND_MAX) begin
			r = PEND_W'(PEND_MAX);
		end else begin
			r = PEND_W'(n);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tbsw_cell.sv =====
// One handle slot of the watchdog table.
// Claims the alloc token when empty, clears itself on a matching recycle.
// Depends on tbsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbsw_cell
	import tbsw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_cmd_t  cmd,
	input  wire logic       claim_in,
	output logic            claim_out,
	output cell_stat_t      stat
);

	logic [HANDLE_W-1:0] slot_q;
	logic [HANDLE_W-1:0] slot_next;
	logic                occ;
	logic                take;
	logic                hit;

	assign occ  = (slot_q != '0);
	assign take = claim_in && !occ;
	// token moves on past an occupied slot
	assign claim_out = claim_in && occ;
	// handle zero matches every empty slot
	assign hit = cmd.recycle && (slot_q == cmd.handle);

	always_comb begin
		slot_next = slot_q;
		if (take) begin
			slot_next = cmd.handle;
		end else if (hit) begin
			slot_next = '0;
		end
	end

	assign stat.hit      = hit;
	assign stat.occ      = occ;
	assign stat.occ_next = (slot_next != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.en) begin
			slot_q <= slot_next;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tx_buffer_stall_watchdog_top.sv =====
// Channel | Dir | Handshake          | Word
// req     | in  | req_valid/stall    | func, handle
// rsp     | out | rsp_valid/stall    | pending_count, stuck, restart_request
//
// One word per cycle while req_stall is low; its result shows in the rsp register the next cycle.
// The alloc token ripples through the row of slot cells within that cycle.
// req_stall is high only while a result sits in rsp and rsp_stall holds it.
// Reset empties every slot and clears the progress and last seen counters.
// Top level of the watchdog; depends on tbsw_pkg and tbsw_cell.
`timescale 1ns / 1ps
`default_nettype none

module tx_buffer_stall_watchdog_top
	import tbsw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	logic                accept;
	cell_cmd_t           cmd;
	logic [SLOTS:0]      claim;
	cell_stat_t          stat [SLOTS];
	logic [SLOTS-1:0]    hit_v;
	logic [SLOTS-1:0]    occ_v;
	logic [SLOTS-1:0]    occ_next_v;
	logic [31:0]         progress_q;
	logic [31:0]         last_seen_q;
	logic                reported_q;
	logic                is_tick;
	logic                tick_busy;
	logic                stalled_now;
	rsp_word_t           rsp_next;

	assign req_stall = rsp_valid && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign cmd.en      = accept;
	assign cmd.alloc   = (func_t'(req.func) == FUNC_ALLOC);
	assign cmd.recycle = (func_t'(req.func) == FUNC_RECYCLE);
	assign cmd.handle  = req.handle;

	assign claim[0] = cmd.alloc && (req.handle != '0);

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		tbsw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.claim_in (claim[g]),
			.claim_out(claim[g+1]),
			.stat     (stat[g])
		);
		assign hit_v[g]      = stat[g].hit;
		assign occ_v[g]      = stat[g].occ;
		assign occ_next_v[g] = stat[g].occ_next;
	end

	assign is_tick     = (func_t'(req.func) == FUNC_TICK);
	assign tick_busy   = is_tick && (occ_v != '0);
	assign stalled_now = tick_busy && (progress_q == last_seen_q);

	always_comb begin
		rsp_next.pending_count   = sat_pending(count_ones(occ_next_v));
		rsp_next.stuck           = stalled_now;
		rsp_next.restart_request = stalled_now && !reported_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q  <= '0;
			last_seen_q <= '0;
			reported_q  <= 1'b0;
		end else if (accept) begin
			if (cmd.recycle) begin
				progress_q <= progress_q + 32'(count_ones(hit_v));
			end
			if (tick_busy && !stalled_now) begin
				last_seen_q <= progress_q;
			end
			if (stalled_now) begin
				reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (accept) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp <= rsp_next;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tbsw_checker.sv =====
// Port-level checks for the watchdog top level, attached by bind.
// Depends on tbsw_pkg and tx_buffer_stall_watchdog_top.
`timescale 1ns / 1ps
`default_nettype none

module tbsw_checker
	import tbsw_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire req_word_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire rsp_word_t rsp
);

	logic restart_seen_q;
	logic rsp_take;

	assign rsp_take = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_seen_q <= 1'b0;
		end else if (rsp_take && rsp.restart_request) begin
			restart_seen_q <= 1'b1;
		end
	end

	a_restart_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && rsp.restart_request |-> !restart_seen_q)
		else $error("restart request delivered twice");

	a_restart_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.restart_request |-> rsp.stuck)
		else $error("restart request without stuck");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled with no held result");

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted word gave no result");

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.pending_count) <= 32'(SLOTS)))
		else $error("pending count above slot count");

endmodule

bind tx_buffer_stall_watchdog_top tbsw_checker u_tbsw_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the transmit buffer stall watchdog: a directed table, then random words.
// Each response is checked against its table value or a predictor of the slot table and counters.
// Depends on tbsw_pkg and tx_buffer_stall_watchdog_top.
`timescale 1ns / 1ps

module testbench;
	import tbsw_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RAND_PER_PHASE = 375;

	typedef struct {
		func_t       func;
		logic [31:0] handle;
		bit          lit;
		rsp_word_t   want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// predictor state
	logic [HANDLE_W-1:0] slot_tab [SLOTS];
	logic [31:0]         progress_cnt;
	logic [31:0]         seen_cnt;
	bit                  fail_flag;

	rsp_word_t due_q [$];
	dir_row_t  dir_tab [$];
	int        errors = 0;
	int        cycles = 0;
	int        src_idle_pct = 0;
	int        snk_idle_pct = 0;
	int        hold_ask = 0;

	tx_buffer_stall_watchdog_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("tx_buffer_stall_watchdog_top: mismatch");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("ERROR t=%0t %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	function automatic int slots_in_use();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_tab[i] != '0) begin
				n++;
			end
		end
		return n;
	endfunction

	task automatic predict_status(input req_word_t w, output rsp_word_t r);
		bit placed;
		int n;
		placed = 0;
		r = '0;
		case (func_t'(w.func))
			FUNC_ALLOC: begin
				if (w.handle != '0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!placed && slot_tab[i] == '0) begin
							slot_tab[i] = w.handle;
							placed = 1;
						end
					end
				end
			end
			FUNC_RECYCLE: begin
				// handle zero matches every empty slot and still counts as progress
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_tab[i] == w.handle) begin
						slot_tab[i] = '0;
						progress_cnt = progress_cnt + 32'd1;
					end
				end
			end
			FUNC_TICK: begin
				if (slots_in_use() != 0) begin
					if (progress_cnt != seen_cnt) begin
						seen_cnt = progress_cnt;
					end else begin
						r.stuck = 1'b1;
						if (!fail_flag) begin
							r.restart_request = 1'b1;
							fail_flag = 1;
						end
					end
				end
			end
			default: ;
		endcase
		n = slots_in_use();
		r.pending_count = (n > 15) ? PEND_W'(15) : PEND_W'(n);
	endtask

	function automatic logic [31:0] pick_handle();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75) begin
			return 32'($urandom_range(1, 12));
		end else if (p < 95) begin
			return $urandom;
		end
		return '0;
	endfunction

	// mostly a working mix of allocs and returns of live handles, some noise
	function automatic req_word_t next_random_word();
		req_word_t w;
		int        r;
		int        k;
		bit        found;
		r = $urandom_range(0, 99);
		found = 0;
		w.handle = pick_handle();
		if (r < 3) begin
			w.func = FUNC_NONE;
			w.handle = $urandom;
		end else if (r < 40) begin
			w.func = FUNC_ALLOC;
		end else if (r < 75) begin
			w.func = FUNC_RECYCLE;
			if ($urandom_range(0, 99) < 75) begin
				k = $urandom_range(0, SLOTS - 1);
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && slot_tab[(k + i) % SLOTS] != '0) begin
						w.handle = slot_tab[(k + i) % SLOTS];
						found = 1;
					end
				end
			end
		end else begin
			w.func = FUNC_TICK;
		end
		return w;
	endfunction

	// offer one word, wait for the handshake, then book its expected result
	task automatic put_word(input req_word_t w, input bit lit, input rsp_word_t lit_want);
		rsp_word_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = w;
		req_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		predict_status(w, r);
		due_q.push_back(lit ? lit_want : r);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (due_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_random(input int count);
		req_word_t w;
		int        taken;
		taken = 0;
		while (taken < count) begin
			w = next_random_word();
			put_word(w, 1'b0, '0);
			if (func_t'(w.func) != FUNC_NONE) begin
				taken++;
			end
		end
	endtask

	task automatic add_row(input func_t f, input logic [31:0] h, input bit lit,
			input int pend, input bit stk, input bit rst);
		dir_row_t row;
		row.func = f;
		row.handle = h;
		row.lit = lit;
		row.want.pending_count = PEND_W'(pend);
		row.want.stuck = stk;
		row.want.restart_request = rst;
		dir_tab.push_back(row);
	endtask

	// receiver: random stalls, or a long hold when asked
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask != 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else begin
				rsp_stall = arst_n && ($urandom_range(0, 99) < snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_q.size() == 0) begin
				report_mismatch("response word with nothing due", 0, 1);
			end else begin
				want = due_q.pop_front();
				if (rsp.pending_count !== want.pending_count) begin
					report_mismatch("pending_count", int'(want.pending_count),
						int'(rsp.pending_count));
				end
				if (rsp.stuck !== want.stuck) begin
					report_mismatch("stuck", int'(want.stuck), int'(rsp.stuck));
				end
				if (rsp.restart_request !== want.restart_request) begin
					report_mismatch("restart_request", int'(want.restart_request),
						int'(rsp.restart_request));
				end
			end
		end
	end

	initial begin
		req_word_t w;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_tab[i] = '0;
		end
		progress_cnt = '0;
		seen_cnt = '0;
		fail_flag = 0;

		// expected column only where it is obvious; zero-lit rows use the predictor
		add_row(FUNC_TICK,    32'h0000_0000, 1, 0, 0, 0);  // tick on empty table
		add_row(FUNC_ALLOC,   32'h0000_0000, 1, 0, 0, 0);  // failed allocation
		add_row(FUNC_NONE,    32'hFFFF_FFFF, 1, 0, 0, 0);  // unused code
		add_row(FUNC_RECYCLE, 32'h0000_0000, 1, 0, 0, 0);  // zero hits all empty slots
		add_row(FUNC_ALLOC,   32'hFFFF_FFFF, 1, 1, 0, 0);
		add_row(FUNC_TICK,    32'h0000_0000, 0, 0, 0, 0);
		add_row(FUNC_TICK,    32'h0000_0000, 1, 1, 1, 1);  // first stuck, restart
		add_row(FUNC_TICK,    32'h0000_0000, 1, 1, 1, 0);  // restart only once
		add_row(FUNC_ALLOC,   32'h0000_0001, 0, 0, 0, 0);
		add_row(FUNC_ALLOC,   32'h0000_0002, 0, 0, 0, 0);
		add_row(FUNC_ALLOC,   32'h8000_0000, 0, 0, 0, 0);
		add_row(FUNC_ALLOC,   32'h7FFF_FFFF, 0, 0, 0, 0);
		add_row(FUNC_ALLOC,   32'h0000_0005, 0, 0, 0, 0);
		add_row(FUNC_ALLOC,   32'h0000_0006, 0, 0, 0, 0);
		add_row(FUNC_ALLOC,   32'hFFFF_FFFF, 1, 8, 0, 0);  // duplicate fills the table
		add_row(FUNC_ALLOC,   32'h1234_5678, 1, 8, 0, 0);  // full table drops it
		add_row(FUNC_RECYCLE, 32'hDEAD_BEEF, 1, 8, 0, 0);  // unknown handle
		add_row(FUNC_NONE,    32'h0000_0000, 1, 8, 0, 0);
		add_row(FUNC_TICK,    32'h0000_0000, 1, 8, 1, 0);
		add_row(FUNC_RECYCLE, 32'hFFFF_FFFF, 1, 6, 0, 0);  // clears both copies
		add_row(FUNC_TICK,    32'h0000_0000, 1, 6, 0, 0);
		add_row(FUNC_RECYCLE, 32'h0000_0000, 1, 6, 0, 0);
		add_row(FUNC_TICK,    32'h0000_0000, 0, 0, 0, 0);
		add_row(FUNC_TICK,    32'h0000_0000, 1, 6, 1, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 28;
		snk_idle_pct = 71;
		foreach (dir_tab[i]) begin
			w.func = dir_tab[i].func;
			w.handle = dir_tab[i].handle;
			put_word(w, dir_tab[i].lit, dir_tab[i].want);
		end

		// long receiver hold while words keep coming: the block backs up
		hold_ask = 60;
		run_random(RAND_PER_PHASE);
		drain();

		src_idle_pct = 71;
		snk_idle_pct = 28;
		run_random(RAND_PER_PHASE);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_random(RAND_PER_PHASE);
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tx_buffer_stall_watchdog_top: match");
		end else begin
			$display("tx_buffer_stall_watchdog_top: mismatch");
		end
		$finish;
	end

endmodule
